FILE: sv/rf_link_failsafe_command_relay_unit_macros.svh
// Assertion macros for the radio command relay.
// Included by the relay module, which carries the concurrent checks; no other dependencies.
`ifndef RF_LINK_FAILSAFE_COMMAND_RELAY_UNIT_MACROS_SVH
`define RF_LINK_FAILSAFE_COMMAND_RELAY_UNIT_MACROS_SVH

// Check a property on the rising clock edge, disabled while reset is low.
`define RFCR_ASSERT_CLK(clk, rstn, name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Same check on the default clock and reset names of this project.
`define RFCR_ASSERT(name, prop, msg) \
  `RFCR_ASSERT_CLK(clk_i, rst_ni, name, prop, msg)

`endif

FILE: sv/rfcr_pkg.sv
// Types and constants of the radio command relay.
// Used by the stream interface users and the top level; no dependencies.
package rfcr_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_RANGE = 2'd2;

  localparam logic KIND_CMD = 1'b0;
  localparam logic KIND_ACK = 1'b1;

  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_PERIOD  = 2'd1;
  localparam logic [1:0] REG_BRAKE   = 2'd2;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [7:0]  PERIOD_RST  = 8'd20;
  localparam logic [7:0]  BRAKE_RST   = 8'd100;

  localparam int unsigned ELAPSED_W   = 17;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [15:0] RANGE_NONE  = 16'hFFFF;

  typedef struct packed {
    logic [1:0]        op;
    logic signed [7:0] rf_steering;
    logic [7:0]        rf_throttle;
    logic [7:0]        rf_brake;
    logic [7:0]        rf_buttons;
    logic [7:0]        rf_sequence;
    logic [15:0]       range_word;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic signed [7:0] cmd_steering;
    logic [7:0]        cmd_throttle;
    logic [7:0]        cmd_brake;
    logic [7:0]        cmd_buttons;
    logic [7:0]        cmd_sequence;
    logic [7:0]        echo_sequence;
    logic [15:0]       ack_range;
    logic [2:0]        slow_slot;
  } out_item_t;

endpackage

FILE: sv/rfcr_stream_if.sv
// Valid/ready stream channel carrying one item per handshake.
// Payload type is a parameter; the relay uses the structs of rfcr_pkg.
interface rfcr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/rf_link_failsafe_command_relay_unit.sv
// Radio command relay: acks, latches radio frames; periodic drive commands; link watchdog.
// Uses rfcr_pkg, rfcr_stream_if and the assertion macros header.
// An item is registered at accept; its result, if any, goes to the result register.
// Throughput: one item per cycle unless out_o stalls; input and result regs decouple.
// Reset: asynchronous, active low; safe stop, range all ones, registers at reset values.
`include "rf_link_failsafe_command_relay_unit_macros.svh"

module rf_link_failsafe_command_relay_unit #(
  parameter int unsigned SLOW_SLOTS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rfcr_stream_if.sink                    in_i,
  rfcr_stream_if.source                  out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rfcr_pkg::PADDR_W-1:0]   paddr,
  input  logic [rfcr_pkg::PDATA_W-1:0]   pwdata,
  output logic [rfcr_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned SlotW = (SLOW_SLOTS > 1) ? $clog2(SLOW_SLOTS) : 1;
  localparam logic [SlotW-1:0] SlotLast = SlotW'(SLOW_SLOTS - 1);

  logic [15:0] timeout_q;
  logic [7:0]  period_q;
  logic [7:0]  brake_q;

  logic                 in_valid_q;
  rfcr_pkg::in_item_t   in_q;
  logic                 out_valid_q;
  rfcr_pkg::out_item_t  out_q;

  logic [rfcr_pkg::ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [7:0]       period_cnt_q, period_cnt_d;
  logic             oper_q, oper_d;
  logic signed [7:0] held_steering_q, held_steering_d;
  logic [7:0]       held_throttle_q, held_throttle_d;
  logic [7:0]       held_brake_q, held_brake_d;
  logic [7:0]       held_buttons_q, held_buttons_d;
  logic [7:0]       seq_q, seq_d;
  logic [15:0]      range_q, range_d;
  logic [SlotW-1:0] slot_q, slot_d;

  logic                advance;
  logic                fire;
  logic                has_result;
  logic                emit_cmd;
  logic [8:0]          slot_ext;
  logic [7:0]          period_inc;
  logic                cfg_wr;
  rfcr_pkg::out_item_t result_d;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= rfcr_pkg::TIMEOUT_RST;
      period_q  <= rfcr_pkg::PERIOD_RST;
      brake_q   <= rfcr_pkg::BRAKE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        rfcr_pkg::REG_TIMEOUT: timeout_q <= pwdata[15:0];
        rfcr_pkg::REG_PERIOD:  period_q  <= pwdata[7:0];
        rfcr_pkg::REG_BRAKE:   brake_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      rfcr_pkg::REG_TIMEOUT: prdata = rfcr_pkg::PDATA_W'(timeout_q);
      rfcr_pkg::REG_PERIOD:  prdata = rfcr_pkg::PDATA_W'(period_q);
      rfcr_pkg::REG_BRAKE:   prdata = rfcr_pkg::PDATA_W'(brake_q);
      default:               prdata = '0;
    endcase
  end

  // Handshake
  assign advance    = !out_valid_q || out_o.ready;
  assign fire       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_i.data;
    end
  end

  // Item processing
  assign period_inc = period_cnt_q + 8'd1;
  assign slot_ext   = 9'(slot_q);

  always_comb begin
    elapsed_d       = elapsed_q;
    period_cnt_d    = period_cnt_q;
    oper_d          = oper_q;
    held_steering_d = held_steering_q;
    held_throttle_d = held_throttle_q;
    held_brake_d    = held_brake_q;
    held_buttons_d  = held_buttons_q;
    seq_d           = seq_q;
    range_d         = range_q;
    slot_d          = slot_q;
    has_result      = 1'b0;
    emit_cmd        = 1'b0;
    result_d        = '0;

    priority if (in_q.op == rfcr_pkg::OP_TICK) begin
      if (elapsed_q != rfcr_pkg::ELAPSED_MAX) begin
        elapsed_d = elapsed_q + 1'b1;
      end
      if (elapsed_d > {1'b0, timeout_q}) begin
        oper_d = 1'b0;
      end
      period_cnt_d = period_inc;
      if (period_inc >= period_q) begin
        emit_cmd              = 1'b1;
        has_result            = 1'b1;
        period_cnt_d          = '0;
        result_d.kind         = rfcr_pkg::KIND_CMD;
        result_d.cmd_sequence = seq_q;
        seq_d                 = seq_q + 8'd1;
        if (oper_d) begin
          result_d.cmd_steering = held_steering_q;
          result_d.cmd_throttle = held_throttle_q;
          result_d.cmd_brake    = held_brake_q;
          result_d.cmd_buttons  = held_buttons_q;
        end else begin
          result_d.cmd_brake    = brake_q;
        end
      end
    end else if (in_q.op == rfcr_pkg::OP_FRAME) begin
      held_steering_d        = in_q.rf_steering;
      held_throttle_d        = in_q.rf_throttle;
      held_brake_d           = in_q.rf_brake;
      held_buttons_d         = in_q.rf_buttons;
      elapsed_d              = '0;
      oper_d                 = 1'b1;
      has_result             = 1'b1;
      result_d.kind          = rfcr_pkg::KIND_ACK;
      result_d.echo_sequence = in_q.rf_sequence;
      result_d.ack_range     = range_q;
      result_d.slow_slot     = slot_ext[2:0];
      slot_d                 = (slot_q == SlotLast) ? '0 : slot_q + 1'b1;
    end else if (in_q.op == rfcr_pkg::OP_RANGE) begin
      range_d = in_q.range_word;
    end else begin
      has_result = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q       <= '0;
      period_cnt_q    <= '0;
      oper_q          <= 1'b0;
      held_steering_q <= '0;
      held_throttle_q <= '0;
      held_brake_q    <= '0;
      held_buttons_q  <= '0;
      seq_q           <= '0;
      range_q         <= rfcr_pkg::RANGE_NONE;
      slot_q          <= '0;
    end else if (fire) begin
      elapsed_q       <= elapsed_d;
      period_cnt_q    <= period_cnt_d;
      oper_q          <= oper_d;
      held_steering_q <= held_steering_d;
      held_throttle_q <= held_throttle_d;
      held_brake_q    <= held_brake_d;
      held_buttons_q  <= held_buttons_d;
      seq_q           <= seq_d;
      range_q         <= range_d;
      slot_q          <= slot_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_result) begin
      out_q <= result_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `RFCR_ASSERT(a_frame_acks, (fire && in_q.op == rfcr_pkg::OP_FRAME) |=> (out_valid_q && out_q.kind == rfcr_pkg::KIND_ACK), "radio frame not acknowledged")
  `RFCR_ASSERT(a_range_silent, (fire && in_q.op == rfcr_pkg::OP_RANGE) |=> !out_valid_q, "distance message gave a result")
  `RFCR_ASSERT(a_seq_advance, (fire && emit_cmd) |=> (seq_q == $past(seq_q) + 8'd1), "command sequence did not advance")
  `RFCR_ASSERT(a_ready_when_empty, !out_valid_q |-> in_i.ready, "input stalled with empty result register")

endmodule

FILE: bench/rf_link_failsafe_command_relay_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the radio command relay: ticks, radio frames and distance items
// go in, and every drive command and acknowledgement is predicted and compared field by field.
// Depends on rfcr_pkg, rfcr_stream_if and rf_link_failsafe_command_relay_unit.
module rf_link_failsafe_command_relay_unit_test;

  localparam logic [1:0]  OP_NONE     = 2'd3;
  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam int unsigned SLOTS       = 8;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned IN_W        = $bits(rfcr_pkg::in_item_t);

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [rfcr_pkg::PADDR_W-1:0] paddr;
  logic [rfcr_pkg::PDATA_W-1:0] pwdata;
  logic [rfcr_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  rfcr_stream_if #(.T(rfcr_pkg::in_item_t))  in_ch ();
  rfcr_stream_if #(.T(rfcr_pkg::out_item_t)) out_ch ();

  rf_link_failsafe_command_relay_unit #(
    .SLOW_SLOTS(SLOTS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // relay state as predicted
  logic [15:0]                    timeout_ticks;
  logic [7:0]                     period_ticks;
  logic [7:0]                     safe_brake;
  logic [rfcr_pkg::ELAPSED_W-1:0] elapsed;
  logic [7:0]                     period_cnt;
  logic                           link_up;
  logic signed [7:0]              steer_q;
  logic [7:0]                     throttle_q;
  logic [7:0]                     brake_q;
  logic [7:0]                     buttons_q;
  logic [7:0]                     cmd_seq;
  logic [15:0]                    range_q;
  logic [2:0]                     slot;

  rfcr_pkg::in_item_t  in_items_q[$];
  rfcr_pkg::out_item_t due_outputs_q[$];
  int        items_queued;
  int        items_taken;
  int        failures;
  int        quiet_cycles;
  int        send_gap;
  int        hold_cnt;
  bit        in_taken;
  bit        steady;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task automatic relay_step(input rfcr_pkg::in_item_t it);
    rfcr_pkg::out_item_t res;
    res = '0;
    case (it.op)
      rfcr_pkg::OP_TICK: begin
        if (elapsed != rfcr_pkg::ELAPSED_MAX) elapsed++;
        period_cnt++;
        if (elapsed > {1'b0, timeout_ticks}) link_up = 1'b0;
        if (period_cnt >= period_ticks) begin
          period_cnt = '0;
          res.kind = rfcr_pkg::KIND_CMD;
          if (link_up) begin
            res.cmd_steering = steer_q;
            res.cmd_throttle = throttle_q;
            res.cmd_brake    = brake_q;
            res.cmd_buttons  = buttons_q;
          end else begin
            res.cmd_brake = safe_brake;
          end
          res.cmd_sequence = cmd_seq;
          cmd_seq++;
          due_outputs_q.push_back(res);
        end
      end
      rfcr_pkg::OP_FRAME: begin
        steer_q    = it.rf_steering;
        throttle_q = it.rf_throttle;
        brake_q    = it.rf_brake;
        buttons_q  = it.rf_buttons;
        elapsed    = '0;
        link_up    = 1'b1;
        res.kind          = rfcr_pkg::KIND_ACK;
        res.echo_sequence = it.rf_sequence;
        res.ack_range     = range_q;
        res.slow_slot     = slot;
        slot = 3'((slot + 1) % SLOTS);
        due_outputs_q.push_back(res);
      end
      rfcr_pkg::OP_RANGE: range_q = it.range_word;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    bit                  in_fire;
    bit                  out_fire;
    bit                  wr_fire;
    rfcr_pkg::out_item_t want;
    rfcr_pkg::out_item_t got;
    if (rst_ni) begin
      in_fire  = in_ch.valid && in_ch.ready;
      out_fire = out_ch.valid && out_ch.ready;
      wr_fire  = psel && penable && pwrite;
      in_taken <= in_fire;
      if (in_fire) begin
        relay_step(in_ch.data);
        items_taken++;
      end
      if (out_fire) begin
        got = out_ch.data;
        if (due_outputs_q.size() == 0) begin
          $error("result item with nothing due: kind %0d seq 0x%0h",
                 got.kind, got.cmd_sequence);
          failures++;
        end else begin
          want = due_outputs_q.pop_front();
          check_field("kind", 16'(want.kind), 16'(got.kind));
          check_field("cmd_steering", 16'(want.cmd_steering), 16'(got.cmd_steering));
          check_field("cmd_throttle", 16'(want.cmd_throttle), 16'(got.cmd_throttle));
          check_field("cmd_brake", 16'(want.cmd_brake), 16'(got.cmd_brake));
          check_field("cmd_buttons", 16'(want.cmd_buttons), 16'(got.cmd_buttons));
          check_field("cmd_sequence", 16'(want.cmd_sequence), 16'(got.cmd_sequence));
          check_field("echo_sequence", 16'(want.echo_sequence), 16'(got.echo_sequence));
          check_field("ack_range", want.ack_range, got.ack_range);
          check_field("slow_slot", 16'(want.slow_slot), 16'(got.slow_slot));
        end
      end
      quiet_cycles <= (in_fire || out_fire || wr_fire) ? 0 : quiet_cycles + 1;
    end
  end

  always @(negedge clk_i) begin : driver
    rfcr_pkg::in_item_t next;
    if (rst_ni && (!in_ch.valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (in_items_q.size() > 0 && !steady && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 18) - 1;
        in_ch.valid <= 1'b0;
      end else if (in_items_q.size() > 0) begin
        next = in_items_q.pop_front();
        in_ch.data  <= next;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : receiver
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else if (!steady && $urandom_range(0, 9) == 0) begin
      hold_cnt = $urandom_range(1, 18) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic rfcr_pkg::in_item_t rand_item(input logic [1:0] op);
    rfcr_pkg::in_item_t it;
    it    = IN_W'({$urandom, $urandom});
    it.op = op;
    return it;
  endfunction

  task automatic send(input rfcr_pkg::in_item_t it);
    in_items_q.push_back(it);
    items_queued++;
  endtask

  task automatic send_frame(input logic [7:0] steer, input logic [7:0] thr, input logic [7:0] brk,
                            input logic [7:0] btn, input logic [7:0] seq);
    rfcr_pkg::in_item_t it;
    it             = rand_item(rfcr_pkg::OP_FRAME);
    it.rf_steering = steer;
    it.rf_throttle = thr;
    it.rf_brake    = brk;
    it.rf_buttons  = btn;
    it.rf_sequence = seq;
    send(it);
  endtask

  task automatic send_range(input logic [15:0] range_val);
    rfcr_pkg::in_item_t it;
    it            = rand_item(rfcr_pkg::OP_RANGE);
    it.range_word = range_val;
    send(it);
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) send(rand_item(rfcr_pkg::OP_TICK));
  endtask

  // hold until all items are in and all results out, then let stragglers finish
  task automatic settle();
    do @(negedge clk_i); while (items_taken != items_queued || due_outputs_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= rfcr_pkg::PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      rfcr_pkg::REG_TIMEOUT: timeout_ticks = value[15:0];
      rfcr_pkg::REG_PERIOD:  period_ticks  = value[7:0];
      rfcr_pkg::REG_BRAKE:   safe_brake    = value[7:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] tmo, input logic [7:0] per, input logic [7:0] brk);
    settle();
    write_reg(rfcr_pkg::REG_TIMEOUT, 32'(tmo));
    write_reg(rfcr_pkg::REG_PERIOD, 32'(per));
    write_reg(rfcr_pkg::REG_BRAKE, 32'(brk));
  endtask

  task automatic random_phase(input int n, input int frame_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < frame_pct) send(rand_item(rfcr_pkg::OP_FRAME));
      else if (r < frame_pct + 6) send(rand_item(rfcr_pkg::OP_RANGE));
      else if (r < frame_pct + 9) send(rand_item(OP_NONE));
      else send(rand_item(rfcr_pkg::OP_TICK));
    end
  endtask

  initial begin : watchdog
    do @(posedge clk_i); while (quiet_cycles < QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    timeout_ticks = rfcr_pkg::TIMEOUT_RST;
    period_ticks  = rfcr_pkg::PERIOD_RST;
    safe_brake    = rfcr_pkg::BRAKE_RST;
    elapsed       = '0;
    period_cnt    = '0;
    link_up       = 1'b0;
    steer_q       = '0;
    throttle_q    = '0;
    brake_q       = '0;
    buttons_q     = '0;
    cmd_seq       = '0;
    range_q       = rfcr_pkg::RANGE_NONE;
    slot          = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: field extremes, no range yet, ignored op, one held command
    send_frame(8'h80, 8'h00, 8'hFF, 8'hFF, 8'h00);
    send_range(16'h0000);
    send_frame(8'h7F, 8'hFF, 8'h00, 8'h00, 8'hFF);
    send_range(16'hFFFF);
    send(rand_item(OP_NONE));
    send_ticks(20);

    // zero timeout and zero period: safe stop on the first tick, command every tick
    configure(16'd0, 8'd0, 8'hFF);
    send_frame(8'h55, 8'hAA, 8'h33, 8'hCC, 8'h5A);
    send_range(16'h8001);
    send_ticks(3);

    settle();
    write_reg(REG_UNUSED, $urandom);

    configure(16'd1, 8'd1, 8'd0);
    random_phase(70, 25);
    configure(16'($urandom_range(2, 30)), 8'($urandom_range(2, 6)), 8'($urandom));
    random_phase(80, 15);
    configure(16'($urandom_range(20, 200)), 8'($urandom_range(1, 12)), 8'($urandom));
    random_phase(80, 8);
    configure(16'hFFFF, 8'hFF, 8'($urandom));
    random_phase(60, 20);
    configure(16'($urandom_range(1, 50)), 8'($urandom_range(1, 8)), 8'($urandom));
    random_phase(80, 12);

    // link held, then lost past the timeout, then regained; no idling
    steady = 1'b1;
    configure(16'd40, 8'd3, 8'hFF);
    send(rand_item(rfcr_pkg::OP_FRAME));
    send_ticks(45);
    send(rand_item(rfcr_pkg::OP_FRAME));
    send_ticks(10);

    settle();
    repeat (8) @(posedge clk_i);
    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/rfcr_pkg.sv
sv/rfcr_stream_if.sv
sv/rf_link_failsafe_command_relay_unit.sv
bench/rf_link_failsafe_command_relay_unit_test.sv
